@@ hdl/assert_macros.svh @@
// Assertion macros shared by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with explicit clock and active-low reset.
`define PTI_ASSERT_CR(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define PTI_ASSERT(name, prop, msg) \
    `PTI_ASSERT_CR(name, i_clk, i_rst_n, prop, msg)

`endif

@@ hdl/pti_pkg.sv @@
// Shared constants, types and helper functions of the periodic trilinear interpolator.
package pti_pkg;

    localparam int MAX_DIM = 32;
    localparam int IDXW    = $clog2(MAX_DIM);
    localparam int ESW     = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(DEPTH);

    // scaled coordinate r*n, floor part, and its magnitude fed to the remainder unit
    localparam int SW      = 33 + ESW;
    localparam int BW      = SW - 24;
    localparam int VW      = BW - 1;
    localparam int CW      = $clog2(VW + 1);

    localparam int WW      = 16;
    localparam int WCW     = WW + 1;
    localparam int ACCW    = 50;
    localparam int KW      = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef struct packed {
        logic [2:0][IDXW-1:0] i0;
        logic [2:0][IDXW-1:0] i1;
        logic [2:0][WW-1:0]   w;
    } t_geom;

    function automatic logic [ESW-1:0] eff_size(input logic [5:0] s);
        logic [ESW-1:0] r;
        if (s == 6'd0) begin
            r = ESW'(1);
        end else if (32'(s) > MAX_DIM) begin
            r = ESW'(MAX_DIM);
        end else begin
            r = ESW'(s);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] grid_addr(input logic [IDXW-1:0] x,
                                                input logic [IDXW-1:0] y,
                                                input logic [IDXW-1:0] z);
        return AW'(x) * AW'(MAX_DIM * MAX_DIM) + AW'(y) * AW'(MAX_DIM) + AW'(z);
    endfunction

    // upper corner takes w, lower corner takes 1.0 - w
    function automatic logic [WCW-1:0] axis_weight(input logic [WW-1:0] w, input logic hi);
        logic [WCW-1:0] r;
        if (hi) begin
            r = {1'b0, w};
        end else begin
            r = WCW'(1 << WW) - {1'b0, w};
        end
        return r;
    endfunction

endpackage

@@ hdl/pti_rem.sv @@
// Iterative restoring remainder unit, one quotient bit per cycle.
module pti_rem
    import pti_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [VW-1:0]  i_value,
    input  logic [ESW-1:0] i_size,
    output logic           o_done,
    output logic [ESW-1:0] o_rem
);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [VW-1:0]  r_val;
    logic [ESW-1:0] r_rem;

    logic [ESW:0]   w_trial;
    logic           w_ge;
    logic [ESW-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_val[VW-1]};
        w_ge    = (w_trial >= {1'b0, i_size});
        if (w_ge) begin
            n_rem = ESW'(w_trial - {1'b0, i_size});
        end else begin
            n_rem = ESW'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= r_val << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ hdl/pti_blend.sv @@
// Grid memory and pipelined eight-corner weighted accumulation.
`include "assert_macros.svh"
module pti_blend
    import pti_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_geom       i_geom,
    input  logic        i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0] i_wdata,
    output logic        o_done,
    output logic [31:0] o_value
);

    logic [31:0] mem [DEPTH];

    logic                   r_busy;
    logic [KW-1:0]          r_k;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_done;
    logic                   r_c1;
    logic [2*WCW-1:0]       r_pxy;
    logic [WCW-1:0]         r_wq;
    logic [31:0]            r_rdata;
    logic signed [31:0]     r_samp;
    logic signed [ACCW-1:0] r_acc;
    logic [31:0]            r_value;

    logic                   w_issue;
    logic                   w_finish;
    logic [2:0]             w_kk;
    logic [AW-1:0]          w_raddr;
    logic [3*WCW-1:0]       w_p3;
    logic signed [ACCW-1:0] w_term;
    logic signed [ACCW-17:0] w_q;
    logic [31:0]            w_sat;

    always_comb begin
        w_issue  = r_busy && !r_k[KW-1];
        w_finish = r_busy && r_k[KW-1] && !r_v1 && !r_v2;
        w_kk     = r_k[2:0];
        // corner bits: x from bit 2, y from bit 1, z from bit 0
        w_raddr  = grid_addr(w_kk[2] ? i_geom.i1[AX_X] : i_geom.i0[AX_X],
                             w_kk[1] ? i_geom.i1[AX_Y] : i_geom.i0[AX_Y],
                             w_kk[0] ? i_geom.i1[AX_Z] : i_geom.i0[AX_Z]);
        w_p3     = r_pxy * axis_weight(i_geom.w[AX_Z], r_c1);
        w_term   = $signed({1'b0, r_wq}) * r_samp;
        w_q      = r_acc[ACCW-1:16];
        if (w_q[ACCW-17:31] == {(ACCW-47){w_q[ACCW-17]}}) begin
            w_sat = w_q[31:0];
        end else if (w_q[ACCW-17]) begin
            w_sat = 32'h8000_0000;
        end else begin
            w_sat = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_v1   <= w_issue;
            r_v2   <= r_v1;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_v1   <= 1'b0;
                r_v2   <= 1'b0;
            end else if (w_issue) begin
                r_k <= r_k + KW'(1);
            end else if (w_finish) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // stage 1: x*y weight, stage 2: times z weight (Q1.48 -> Q1.16), stage 3: MAC
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pxy <= axis_weight(i_geom.w[AX_X], w_kk[2])
                   * axis_weight(i_geom.w[AX_Y], w_kk[1]);
            r_c1  <= w_kk[0];
        end
        if (r_v1) begin
            r_wq   <= w_p3[2*WW+WCW-1:2*WW];
            r_samp <= r_rdata;
        end
        if (i_start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + w_term;
        end
        if (w_finish) begin
            r_value <= w_sat;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

    `PTI_ASSERT(a_start_clears, i_start |=> (r_busy && r_k == KW'(0)), "blend start not taken")
    `PTI_ASSERT(a_stage_order, r_v2 |-> $past(r_v1), "MAC beat without weight stage")
    `PTI_ASSERT(a_pipe_busy, (r_v1 || r_v2) |-> r_busy, "corner pipeline active while idle")

endmodule

@@ hdl/periodic_trilinear_interpolator.sv @@
// Top level: handshake, size registers, axis setup sequencer and result register.
//
// Input channel (i_in_valid / o_in_ready) carries one beat per item. A write beat
// (i_op = 0) stores i_write_value at (x, y, z) in the accept cycle and gives no result;
// the block is ready again the next cycle. A query beat (i_op = 1) gives one result on
// the output channel (o_out_valid / i_out_ready, data o_interp_value).
// A query runs one axis at a time through a shared restoring remainder unit that
// retires one bit per cycle. The eight corners then stream from the single grid
// memory read port, one read per cycle, through a three-stage multiply pipeline.
// The input is not ready while a query runs. Results leave through an output
// register, so a new item is taken while an earlier result still waits; a finished
// query waits only if that register is still full.
// Size registers are written on i_cfg_we; the user must write them only while the
// block is idle, as the block itself does not enforce this.
// Reset (synchronous, active low) sets the sizes to 32 and empties the pipeline;
// grid contents are not cleared and must be written before they are read.
`include "assert_macros.svh"
module periodic_trilinear_interpolator
    import pti_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [4:0]  i_write_x,
    input  logic [4:0]  i_write_y,
    input  logic [4:0]  i_write_z,
    input  logic signed [31:0] i_write_value,
    input  logic signed [31:0] i_query_rx,
    input  logic signed [31:0] i_query_ry,
    input  logic signed [31:0] i_query_rz,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_interp_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_AXIS  = 5'b00010,
        S_DIV   = 5'b00100,
        S_BLEND = 5'b01000,
        S_PUSH  = 5'b10000
    } t_state;

    t_state              r_state;
    logic [5:0]          r_size_x;
    logic [5:0]          r_size_y;
    logic [5:0]          r_size_z;
    logic [1:0]          r_ax;
    logic                r_neg;
    logic                r_blend_go;
    logic signed [31:0]  r_qx;
    logic signed [31:0]  r_qy;
    logic signed [31:0]  r_qz;
    t_geom               r_geom;
    logic                r_out_valid;
    logic [31:0]         r_out_value;

    logic                w_in_acc;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic signed [31:0]  w_coord;
    logic [ESW-1:0]      w_n;
    logic signed [SW-1:0] w_s;
    logic [BW-1:0]       w_b;
    logic [VW-1:0]       w_v;
    logic                w_div_done;
    logic [ESW-1:0]      w_rem;
    logic [ESW-1:0]      w_m;
    logic [ESW-1:0]      w_m1;
    logic                w_blend_done;
    logic [31:0]         w_blend_value;
    logic                w_push;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_push     = (r_state == S_PUSH) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_we = w_in_acc && (i_op == OP_WRITE)
            && (32'(i_write_x) < MAX_DIM) && (32'(i_write_y) < MAX_DIM)
            && (32'(i_write_z) < MAX_DIM);
        w_waddr = grid_addr(IDXW'(i_write_x), IDXW'(i_write_y), IDXW'(i_write_z));
    end

    always_comb begin
        case (r_ax)
            AX_X: begin
                w_coord = r_qx;
                w_n     = eff_size(r_size_x);
            end
            AX_Y: begin
                w_coord = r_qy;
                w_n     = eff_size(r_size_y);
            end
            default: begin
                w_coord = r_qz;
                w_n     = eff_size(r_size_z);
            end
        endcase
        w_s = $signed(w_coord) * $signed({1'b0, w_n});
        w_b = w_s[SW-1:24];
        // negative floor: remainder of (-b - 1), mirrored afterwards
        if (w_b[BW-1]) begin
            w_v = ~w_b[VW-1:0];
        end else begin
            w_v = w_b[VW-1:0];
        end
        if (r_neg) begin
            w_m = w_n - ESW'(1) - w_rem;
        end else begin
            w_m = w_rem;
        end
        if (w_m + ESW'(1) == w_n) begin
            w_m1 = '0;
        end else begin
            w_m1 = w_m + ESW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 6'd32;
            r_size_y <= 6'd32;
            r_size_z <= 6'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIZE_X: r_size_x <= i_cfg_data;
                CFG_SIZE_Y: r_size_y <= i_cfg_data;
                CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ax        <= AX_X;
            r_blend_go  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_blend_go <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_op == OP_QUERY) begin
                        r_ax    <= AX_X;
                        r_state <= S_AXIS;
                    end
                end
                S_AXIS: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_ax == AX_Z) begin
                            r_blend_go <= 1'b1;
                            r_state    <= S_BLEND;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_AXIS;
                        end
                    end
                end
                S_BLEND: begin
                    if (w_blend_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_push) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_qx <= i_query_rx;
            r_qy <= i_query_ry;
            r_qz <= i_query_rz;
        end
        if (r_state == S_AXIS) begin
            r_neg          <= w_b[BW-1];
            r_geom.w[r_ax] <= w_s[23:8];
        end
        if (r_state == S_DIV && w_div_done) begin
            r_geom.i0[r_ax] <= IDXW'(w_m);
            r_geom.i1[r_ax] <= IDXW'(w_m1);
        end
        if (w_push) begin
            r_out_value <= w_blend_value;
        end
    end

    pti_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_AXIS),
        .i_value (w_v),
        .i_size  (w_n),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    pti_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_blend_go),
        .i_geom  (r_geom),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_write_value),
        .o_done  (w_blend_done),
        .o_value (w_blend_value)
    );

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_value;

    `PTI_ASSERT(a_query_busy, (w_in_acc && i_op == OP_QUERY) |=> !o_in_ready, "ready during query")
    `PTI_ASSERT(a_div_state, w_div_done |-> (r_state == S_DIV), "remainder done outside axis pass")
    `PTI_ASSERT(a_blend_state, w_blend_done |-> (r_state == S_BLEND), "blend done out of sequence")
    `PTI_ASSERT(a_rem_range, (r_state == S_DIV && w_div_done) |-> (w_rem < w_n), "remainder >= size")

endmodule

@@ test/periodic_trilinear_interpolator_tb.sv @@
// Self-checking testbench for the periodic trilinear interpolator.
`timescale 1ns / 100ps

module periodic_trilinear_interpolator_tb;
    import pti_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic               op;
        logic [4:0]         wx;
        logic [4:0]         wy;
        logic [4:0]         wz;
        logic signed [31:0] value;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
    } grid_beat_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    grid_beat_t         in_beat = '0;
    logic               out_ready = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = CFG_SIZE_X;
    logic [5:0]         cfg_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [31:0] o_interp_value;

    grid_beat_t         pending_beats[$];
    logic signed [31:0] interp_expect[$];

    // predictor state, updated on accepted beats and config writes
    logic signed [31:0] grid_model [DEPTH];
    logic [5:0]         pred_size [3] = '{6'd32, 6'd32, 6'd32};
    // stimulus-side view: sizes planned and cells already loaded
    logic [5:0]         plan_size [3] = '{6'd32, 6'd32, 6'd32};
    bit                 cell_filled [DEPTH];

    int  planned = 0;
    int  fault_count = 0;
    bit  calm = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  stall_left = 0;
    int  hold_requests = 0;
    int  holds_done = 0;

    periodic_trilinear_interpolator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (in_beat.op),
        .i_write_x      (in_beat.wx),
        .i_write_y      (in_beat.wy),
        .i_write_z      (in_beat.wz),
        .i_write_value  (in_beat.value),
        .i_query_rx     (in_beat.rx),
        .i_query_ry     (in_beat.ry),
        .i_query_rz     (in_beat.rz),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_interp_value (o_interp_value),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int size_in_use(input logic [5:0] v);
        if (v == 6'd0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int cell_of(input int x, input int y, input int z);
        return (x * MAX_DIM + y) * MAX_DIM + z;
    endfunction

    // scale by n, floor gives the base cell (wrapped), bits 23..8 give the weight
    function automatic void split_axis(input logic signed [31:0] r, input int n,
                                       output int lo, output int hi, output longint w);
        longint s;
        longint b;
        s = longint'(r) * n;
        b = s >>> 24;
        lo = int'(b % n);
        if (lo < 0) lo += n;
        hi = (lo + 1) % n;
        w = longint'(s[23:8]);
    endfunction

    function automatic logic signed [31:0] blend_corners(input logic signed [31:0] rx,
                                                         input logic signed [31:0] ry,
                                                         input logic signed [31:0] rz);
        int     xi[2], yi[2], zi[2];
        longint wx[2], wy[2], wz[2];
        longint acc;
        longint wq;
        longint v;
        split_axis(rx, size_in_use(pred_size[0]), xi[0], xi[1], wx[1]);
        split_axis(ry, size_in_use(pred_size[1]), yi[0], yi[1], wy[1]);
        split_axis(rz, size_in_use(pred_size[2]), zi[0], zi[1], wz[1]);
        wx[0] = 65536 - wx[1];
        wy[0] = 65536 - wy[1];
        wz[0] = 65536 - wz[1];
        acc = 0;
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++)
                for (int c = 0; c < 2; c++) begin
                    wq = (wx[a] * wy[b] * wz[c]) >> 32;
                    acc += wq * longint'(grid_model[cell_of(xi[a], yi[b], zi[c])]);
                end
        v = acc >>> 16;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic [7:0] k;
        k = $urandom_range(0, 255);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            2: return {k, 24'd0};
            default: return {k, 24'd0} + int'($urandom_range(0, 2)) - 1;
        endcase
    endfunction

    // unused fields of a beat still carry random bits
    function automatic grid_beat_t random_beat();
        grid_beat_t b;
        b.op    = OP_WRITE;
        b.wx    = $urandom;
        b.wy    = $urandom;
        b.wz    = $urandom;
        b.value = $urandom;
        b.rx    = $urandom;
        b.ry    = $urandom;
        b.rz    = $urandom;
        return b;
    endfunction

    task automatic push_write(input int x, input int y, input int z,
                              input logic signed [31:0] value);
        grid_beat_t b;
        b = random_beat();
        b.op    = OP_WRITE;
        b.wx    = x[4:0];
        b.wy    = y[4:0];
        b.wz    = z[4:0];
        b.value = value;
        cell_filled[cell_of(x, y, z)] = 1'b1;
        pending_beats.push_back(b);
        planned++;
    endtask

    // loads any corner not yet written, at times rewrites one corner, then queues the query itself
    task automatic push_query(input logic signed [31:0] rx, input logic signed [31:0] ry,
                              input logic signed [31:0] rz);
        grid_beat_t b;
        int         xi[2], yi[2], zi[2];
        longint     w;
        split_axis(rx, size_in_use(plan_size[0]), xi[0], xi[1], w);
        split_axis(ry, size_in_use(plan_size[1]), yi[0], yi[1], w);
        split_axis(rz, size_in_use(plan_size[2]), zi[0], zi[1], w);
        for (int a = 0; a < 2; a++)
            for (int c = 0; c < 2; c++)
                for (int d = 0; d < 2; d++)
                    if (!cell_filled[cell_of(xi[a], yi[c], zi[d])])
                        push_write(xi[a], yi[c], zi[d], rand_sample());
        if ($urandom_range(0, 3) == 0)
            push_write(xi[$urandom_range(0, 1)], yi[$urandom_range(0, 1)],
                       zi[$urandom_range(0, 1)], rand_sample());
        b = random_beat();
        b.op = OP_QUERY;
        b.rx = rx;
        b.ry = ry;
        b.rz = rz;
        pending_beats.push_back(b);
        planned++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || in_valid || interp_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_sizes(input logic [5:0] sx, input logic [5:0] sy,
                             input logic [5:0] sz);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIZE_X;
        cfg_data  <= sx;
        @(posedge i_clk);
        cfg_index <= CFG_SIZE_Y;
        cfg_data  <= sy;
        @(posedge i_clk);
        cfg_index <= CFG_SIZE_Z;
        cfg_data  <= sz;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        plan_size = '{sx, sy, sz};
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [5:0] sx, input logic [5:0] sy,
                             input logic [5:0] sz, input int budget, input bit hold);
        set_sizes(sx, sy, sz);
        planned = 0;
        while (planned < budget) begin
            if ($urandom_range(0, 3) != 0)
                push_query(rand_coord(), rand_coord(), rand_coord());
            else
                push_write($urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31), rand_sample());
        end
        if (hold) hold_requests++;
        wait_idle();
    endtask

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    // input driver: random bursts of idle beats unless calm
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                in_gap   <= $urandom_range(0, 3);
                in_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                in_beat  <= pending_beats.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done <= hold_requests;
            stall_left <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap   <= out_gap - 1;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            out_gap   <= $urandom_range(0, 3);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: check results first, then fold in this edge's input beat and config
    always @(posedge i_clk) begin
        logic signed [31:0] want;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                if (interp_expect.size() == 0) begin
                    report_fault($sformatf("unexpected result 0x%08h", o_interp_value));
                end else begin
                    want = interp_expect.pop_front();
                    if (o_interp_value !== want)
                        report_fault($sformatf(
                            "interp_value mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                            want, want, o_interp_value, o_interp_value));
                end
            end
            if (in_valid && o_in_ready) begin
                if (in_beat.op == OP_WRITE)
                    grid_model[cell_of(in_beat.wx, in_beat.wy, in_beat.wz)] = in_beat.value;
                else
                    interp_expect.push_back(blend_corners(in_beat.rx, in_beat.ry, in_beat.rz));
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SIZE_X: pred_size[0] = cfg_data;
                    CFG_SIZE_Y: pred_size[1] = cfg_data;
                    CFG_SIZE_Z: pred_size[2] = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        logic signed [31:0] corner_vals [8];
        corner_vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
                        32'sh0001_0000, 32'sh8000_0001, 32'sh7FFF_0000, 32'sh1234_5678};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, at the reset sizes: extreme samples around the origin cell
        for (int k = 0; k < 8; k++)
            push_write(k[2], k[1], k[0], corner_vals[k]);
        push_query(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        push_query(32'sh0004_0000, 32'sh0006_0000, 32'sh0002_0000);
        push_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        // just below zero and top of range both wrap between the last cell and cell 0
        push_query(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
        push_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        wait_idle();

        run_phase(6'd1, 6'd1, 6'd1, 100, 1'b0);
        // zero acts as one, anything past the grid as full size
        run_phase(6'd0, 6'd63, 6'd33, 150, 1'b1);
        run_phase(6'd2, 6'd3, 6'd5, 250, 1'b0);
        run_phase(6'd32, 6'd1, 6'd17, 250, 1'b0);
        for (int k = 0; k < 3; k++)
            run_phase($urandom_range(0, 9), $urandom_range(1, 12), $urandom_range(2, 40),
                      200, 1'b0);
        calm = 1'b1;
        run_phase(6'd32, 6'd32, 6'd32, 200, 1'b0);

        if (fault_count == 0)
            $display("periodic_trilinear_interpolator test passed");
        else
            $display("periodic_trilinear_interpolator test failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("periodic_trilinear_interpolator test failed");
        $finish;
    end

endmodule
